### design/lcr_pkg.sv
// Shared constants and types for the console line command recognizer.
package lcr_pkg;

  localparam int LINE_DEPTH = 1024;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int CAP_N      = 6;

  localparam logic [7:0] CH_NUL  = 8'd0;
  localparam logic [7:0] CH_BS   = 8'd8;
  localparam logic [7:0] CH_TAB  = 8'd9;
  localparam logic [7:0] CH_LF   = 8'd10;
  localparam logic [7:0] CH_CR   = 8'd13;
  localparam logic [7:0] CH_SP   = 8'd32;
  localparam logic [7:0] CH_DEL  = 8'd127;

  localparam logic [2:0] CMD_EMPTY   = 3'd0;
  localparam logic [2:0] CMD_HELP    = 3'd1;
  localparam logic [2:0] CMD_BANNER  = 3'd2;
  localparam logic [2:0] CMD_PROBE   = 3'd3;
  localparam logic [2:0] CMD_UNKNOWN = 3'd4;

  localparam logic KIND_ECHO = 1'b0;
  localparam logic KIND_CMD  = 1'b1;

  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] idx;
    logic [7:0]        data;
  } scan_beat_t;

endpackage

### design/console_line_command_recognizer_top.sv
// Top level of the console line editor with command recognition.
// A byte is accepted in the idle cycle and decoded in the next one, where it waits for a
// stalled output; the input is held until the byte is done. An ordinary byte is echoed, a
// backspace gives BS SP BS (nothing on an empty line), and a line end or a filling byte is
// echoed and then scanned, one store entry per cycle, before the command beat. Output stalls
// hold echo and command steps; reset clears fill count and control, not the line store.
module console_line_command_recognizer_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] echo_byte, [10:8] command, [15:11] zero
  output logic        out_tuser,  // [0] kind
  output logic        out_tlast
);
  import lcr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROC = 3'd1;
  localparam logic [2:0] S_BS2  = 3'd2;
  localparam logic [2:0] S_BS3  = 3'd3;
  localparam logic [2:0] S_SCAN = 3'd4;
  localparam logic [2:0] S_CMD  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] count_r, count_nxt;
  logic [ADDR_W-1:0] idx_r, idx_nxt;
  logic              dv_r, dv_nxt;
  logic [ADDR_W-1:0] didx_r;
  logic [7:0]        byte_r;

  logic              ov_r, ov_nxt;
  logic [7:0]        oecho_r, oecho_nxt;
  logic [2:0]        ocmd_r, ocmd_nxt;
  logic              okind_r, okind_nxt;
  logic              olast_r, olast_nxt;

  logic              emit_ok;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [7:0]        mem_rdata;
  logic              scan_clear;
  scan_beat_t        beat;
  logic [2:0]        command;

  assign emit_ok   = !ov_r || out_tready;
  assign in_tready = (state_r == S_IDLE);

  lcr_ram #(.WIDTH(8), .DEPTH(LINE_DEPTH)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (byte_r),
    .rdata (mem_rdata)
  );

  assign beat.valid = dv_r;
  assign beat.idx   = didx_r;
  assign beat.data  = mem_rdata;

  lcr_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (scan_clear),
    .beat    (beat),
    .command (command)
  );

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    dv_nxt     = 1'b0;
    mem_we     = 1'b0;
    mem_addr   = idx_r;
    scan_clear = 1'b0;
    ov_nxt     = ov_r && !out_tready;
    oecho_nxt  = oecho_r;
    ocmd_nxt   = ocmd_r;
    okind_nxt  = okind_r;
    olast_nxt  = olast_r;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          state_nxt = S_PROC;
        end
      end
      S_PROC: begin
        if (byte_r inside {CH_BS, CH_DEL}) begin
          if (count_r == '0) begin
            state_nxt = S_IDLE;
          end else if (emit_ok) begin
            count_nxt = count_r - ADDR_W'(1);
            ov_nxt    = 1'b1;
            oecho_nxt = CH_BS;
            ocmd_nxt  = CMD_EMPTY;
            okind_nxt = KIND_ECHO;
            olast_nxt = 1'b0;
            state_nxt = S_BS2;
          end
        end else if (byte_r inside {CH_CR, CH_LF}) begin
          if (emit_ok) begin
            ov_nxt     = 1'b1;
            oecho_nxt  = CH_LF;
            ocmd_nxt   = CMD_EMPTY;
            okind_nxt  = KIND_ECHO;
            olast_nxt  = 1'b0;
            idx_nxt    = '0;
            scan_clear = 1'b1;
            state_nxt  = S_SCAN;
          end
        end else if (emit_ok) begin
          mem_we    = 1'b1;
          mem_addr  = count_r;
          count_nxt = count_r + ADDR_W'(1);
          ov_nxt    = 1'b1;
          oecho_nxt = byte_r;
          ocmd_nxt  = CMD_EMPTY;
          okind_nxt = KIND_ECHO;
          if (count_r >= ADDR_W'(LINE_DEPTH - 2)) begin
            olast_nxt  = 1'b0;
            idx_nxt    = '0;
            scan_clear = 1'b1;
            state_nxt  = S_SCAN;
          end else begin
            olast_nxt = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_BS2: begin
        if (emit_ok) begin
          ov_nxt    = 1'b1;
          oecho_nxt = CH_SP;
          olast_nxt = 1'b0;
          state_nxt = S_BS3;
        end
      end
      S_BS3: begin
        if (emit_ok) begin
          ov_nxt    = 1'b1;
          oecho_nxt = CH_BS;
          olast_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        if (idx_r != count_r) begin
          mem_addr = idx_r;
          dv_nxt   = 1'b1;
          idx_nxt  = idx_r + ADDR_W'(1);
        end else if (!dv_r) begin
          state_nxt = S_CMD;
        end
      end
      S_CMD: begin
        if (emit_ok) begin
          ov_nxt    = 1'b1;
          oecho_nxt = CH_NUL;
          ocmd_nxt  = command;
          okind_nxt = KIND_CMD;
          olast_nxt = 1'b1;
          count_nxt = '0;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r   <= '0;
      dv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      dv_r    <= dv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
    didx_r  <= idx_r;
    oecho_r <= oecho_nxt;
    ocmd_r  <= ocmd_nxt;
    okind_r <= okind_nxt;
    olast_r <= olast_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {5'b0, ocmd_r, oecho_r};
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;

endmodule

### design/lcr_ram.sv
// Generic single-port RAM with a registered read.
module lcr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

### design/lcr_scan.sv
// Line scan datapath: finds the trimmed line length and classifies the command.
module lcr_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               clear,
  input  lcr_pkg::scan_beat_t beat,
  output logic [2:0]         command
);
  import lcr_pkg::*;

  logic              zero_seen_r, zero_seen_nxt;
  logic [ADDR_W-1:0] len_r, len_nxt;
  logic [7:0]        cap_r [CAP_N];
  logic              is_blank;
  logic              take;

  assign is_blank = beat.data inside {CH_SP, CH_TAB, CH_CR, CH_LF};
  assign take     = beat.valid && !zero_seen_r && (beat.data != CH_NUL);

  always_comb begin
    zero_seen_nxt = zero_seen_r;
    len_nxt       = len_r;
    if (clear) begin
      zero_seen_nxt = 1'b0;
      len_nxt       = '0;
    end else if (beat.valid && !zero_seen_r) begin
      if (beat.data == CH_NUL) begin
        zero_seen_nxt = 1'b1;
      end else if (!is_blank) begin
        len_nxt = beat.idx + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zero_seen_r <= 1'b0;
      len_r       <= '0;
    end else begin
      zero_seen_r <= zero_seen_nxt;
      len_r       <= len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < CAP_N; i++) begin
      if (take && (beat.idx == ADDR_W'(i))) begin
        cap_r[i] <= beat.data;
      end
    end
  end

  always_comb begin
    if (len_r == '0) begin
      command = CMD_EMPTY;
    end else if (len_r == ADDR_W'(4) && cap_r[0] == "h" && cap_r[1] == "e" &&
                 cap_r[2] == "l" && cap_r[3] == "p") begin
      command = CMD_HELP;
    end else if ((len_r == ADDR_W'(1) && cap_r[0] == "1") ||
                 (len_r == ADDR_W'(6) && cap_r[0] == "b" && cap_r[1] == "a" &&
                  cap_r[2] == "n" && cap_r[3] == "n" && cap_r[4] == "e" &&
                  cap_r[5] == "r")) begin
      command = CMD_BANNER;
    end else if ((len_r == ADDR_W'(1) && cap_r[0] == "2") ||
                 (len_r == ADDR_W'(5) && cap_r[0] == "s" && cap_r[1] == "t" &&
                  cap_r[2] == "a" && cap_r[3] == "c" && cap_r[4] == "k")) begin
      command = CMD_PROBE;
    end else begin
      command = CMD_UNKNOWN;
    end
  end

endmodule
